/* rtl/zoned_disk_sector_translate_defines.svh */
// Assertion helpers for the RTL file that checks itself.
`ifndef ZONED_DISK_SECTOR_TRANSLATE_DEFINES_SVH
`define ZONED_DISK_SECTOR_TRANSLATE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ZDST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zdst same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ZDST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zdst next-cycle check failed");

`endif

/* rtl/zdst_pkg.sv */
`timescale 1ns / 1ps
package zdst_pkg;

  // Zone table depth default
  localparam int unsigned MAX_ZONES_DEF = 16;

  // Datapath widths fixed by the field formats
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned TRACK_W  = 16;
  localparam int unsigned SPT_W    = 12;
  localparam int unsigned HC_W     = 8;
  localparam int unsigned SB_W     = 17;
  localparam int unsigned CAP_W    = 56;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned KIND_W   = 2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRANSLATE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HEAD  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_HEAD_COUNT   = 1'b0;
  localparam logic CFG_SECTOR_BYTES = 1'b1;

  // One zone table entry
  typedef struct packed {
    logic [TRACK_W-1:0] start_track;
    logic [SPT_W-1:0]   track_sectors;
    logic [DIV_W-1:0]   sector_count;
  } zone_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* rtl/zoned_disk_sector_translate.sv */
`timescale 1ns / 1ps
// Zoned disk sector translator. An item is taken when start is high and busy is low;
// busy then stays high until the one result beat appears on res_valid_o for a single
// cycle, with no way for the receiver to stall it, so it must take every beat as it
// comes. Clear, unused kinds, a rejected append and a translate on an empty table go
// straight to the capacity multiply; a stored append first forms the zone's sector
// count and writes the table. A translate that runs divides for the head, walks the
// zone table to the zone that holds the sector, then divides for track and sector:
// one shared 32-bit restoring divider runs twice at one quotient bit per cycle, and
// the zone table, read through one registered port, is walked one zone at a time, read
// then compare. Configuration writes take effect at once and belong in idle time only.
`include "zoned_disk_sector_translate_defines.svh"
module zoned_disk_sector_translate #(
  parameter int unsigned MAX_ZONES = zdst_pkg::MAX_ZONES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [zdst_pkg::SB_W-1:0]       cfg_wdata_i,
  input  logic                            start,
  output logic                            busy,
  input  logic [zdst_pkg::KIND_W-1:0]     kind_i,
  input  logic [zdst_pkg::TRACK_W-1:0]    first_track_i,
  input  logic [zdst_pkg::TRACK_W-1:0]    last_track_i,
  input  logic [zdst_pkg::SPT_W-1:0]      sectors_per_track_i,
  input  logic [zdst_pkg::DIV_W-1:0]      logical_sector_i,
  output logic                            res_valid_o,
  output logic [zdst_pkg::STATUS_W-1:0]   status_o,
  output logic [zdst_pkg::DIV_W-1:0]      head_o,
  output logic [zdst_pkg::TRACK_W-1:0]    track_o,
  output logic [zdst_pkg::SPT_W-1:0]      sector_o,
  output logic [zdst_pkg::CAP_W-1:0]      capacity_bytes_o
);

  localparam int unsigned IdxW  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ZONES + 1);
  localparam int unsigned W     = zdst_pkg::DIV_W;
  localparam int unsigned SpanW = zdst_pkg::TRACK_W + 1;
  localparam int unsigned PerW  = zdst_pkg::HC_W + W;
  localparam int unsigned HalfW = PerW / 2;
  localparam int unsigned MulAW = PerW - HalfW;
  localparam int unsigned MulPW = MulAW + zdst_pkg::SB_W;
  localparam int unsigned AccW  = PerW + zdst_pkg::SB_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_APP_MUL  = 4'd1;
  localparam logic [3:0] S_APP_ADD  = 4'd2;
  localparam logic [3:0] S_DIV_HEAD = 4'd3;
  localparam logic [3:0] S_WALK_RD  = 4'd4;
  localparam logic [3:0] S_WALK_CMP = 4'd5;
  localparam logic [3:0] S_DIV_SEC  = 4'd6;
  localparam logic [3:0] S_CAP_PER  = 4'd7;
  localparam logic [3:0] S_CAP_LO   = 4'd8;
  localparam logic [3:0] S_CAP_HI   = 4'd9;

  logic [3:0]                          state_q, state_d;
  logic [zdst_pkg::HC_W-1:0]           hc_q;
  logic [zdst_pkg::SB_W-1:0]           sb_q;
  logic [CntW-1:0]                     loaded_q, loaded_d;
  logic [W-1:0]                        surface_q, surface_d;
  logic                                valid_q, valid_d;
  logic [zdst_pkg::STATUS_W-1:0]       status_q, status_d;
  logic [W-1:0]                        head_q, head_d;
  logic [zdst_pkg::TRACK_W-1:0]        track_q, track_d;
  logic [zdst_pkg::SPT_W-1:0]          sector_q, sector_d;
  logic [zdst_pkg::CAP_W-1:0]          cap_q, cap_d;
  logic [IdxW-1:0]                     idx_q, idx_d;
  logic [W-1:0]                        sum_q, sum_d;
  logic [W-1:0]                        rest_q, rest_d;
  logic [SpanW-1:0]                    span_q, span_d;
  logic [zdst_pkg::SPT_W-1:0]          spt_q, spt_d;
  logic [zdst_pkg::TRACK_W-1:0]        first_q, first_d;
  logic [W-1:0]                        count_q, count_d;
  logic [PerW-1:0]                     per_q, per_d;
  logic [AccW-1:0]                     acc_q, acc_d;

  logic                                accept;
  logic                                tbl_we;
  zdst_pkg::zone_t                     tbl_wdata;
  zdst_pkg::zone_t                     tbl_rdata;
  zdst_pkg::div_req_t                  div_req;
  zdst_pkg::div_rsp_t                  div_rsp;
  logic [MulAW-1:0]                    mul_a;
  logic [zdst_pkg::SB_W-1:0]           mul_b;
  logic [MulPW-1:0]                    mul_p;
  logic [W:0]                          walk_sum;
  logic [W:0]                          app_total;
  logic                                walk_hit;
  logic [zdst_pkg::SPT_W-1:0]          spt_eff;

  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= zdst_pkg::HC_W'(1);
      sb_q <= zdst_pkg::SB_W'(512);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        zdst_pkg::CFG_HEAD_COUNT:   hc_q <= cfg_wdata_i[zdst_pkg::HC_W-1:0];
        zdst_pkg::CFG_SECTOR_BYTES: sb_q <= cfg_wdata_i;
        default:                    hc_q <= hc_q;
      endcase
    end
  end

  // Shared multiplier: zone sector count, then capacity in two halves
  always_comb begin
    case (state_q)
      S_APP_MUL: begin
        mul_a = MulAW'(span_q);
        mul_b = zdst_pkg::SB_W'(spt_q);
      end
      S_CAP_HI: begin
        mul_a = per_q[PerW-1:HalfW];
        mul_b = sb_q;
      end
      default: begin
        mul_a = MulAW'(per_q[HalfW-1:0]);
        mul_b = sb_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Zone walk and append arithmetic
  assign walk_sum  = {1'b0, sum_q} + {1'b0, tbl_rdata.sector_count};
  assign walk_hit  = ({1'b0, rest_q} < walk_sum) ||
                     (CntW'(idx_q) == loaded_q - CntW'(1));
  assign app_total = {1'b0, surface_q} + {1'b0, count_q};
  assign spt_eff   = (tbl_rdata.track_sectors == '0) ? zdst_pkg::SPT_W'(1)
                                                      : tbl_rdata.track_sectors;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    loaded_d  = loaded_q;
    surface_d = surface_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    head_d    = head_q;
    track_d   = track_q;
    sector_d  = sector_q;
    cap_d     = cap_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    rest_d    = rest_q;
    span_d    = span_q;
    spt_d     = spt_q;
    first_d   = first_q;
    count_d   = count_q;
    per_d     = per_q;
    acc_d     = acc_q;
    tbl_we    = 1'b0;
    tbl_wdata.start_track   = first_q;
    tbl_wdata.track_sectors = spt_q;
    tbl_wdata.sector_count  = count_q;
    div_req.start    = 1'b0;
    div_req.dividend = logical_sector_i;
    div_req.divisor  = surface_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = zdst_pkg::ST_OK;
          head_d   = '0;
          track_d  = '0;
          sector_d = '0;
          state_d  = S_CAP_PER;
          case (kind_i)
            zdst_pkg::KIND_CLEAR: begin
              loaded_d  = '0;
              surface_d = '0;
            end
            zdst_pkg::KIND_APPEND: begin
              if (loaded_q >= CntW'(MAX_ZONES)) begin
                status_d = zdst_pkg::ST_FULL;
              end else if (last_track_i < first_track_i || sectors_per_track_i == '0) begin
                status_d = zdst_pkg::ST_BAD;
              end else begin
                span_d  = SpanW'(last_track_i) - SpanW'(first_track_i) + SpanW'(1);
                spt_d   = sectors_per_track_i;
                first_d = first_track_i;
                state_d = S_APP_MUL;
              end
            end
            zdst_pkg::KIND_TRANSLATE: begin
              if (loaded_q == '0 || surface_q == '0) begin
                status_d = zdst_pkg::ST_EMPTY;
              end else begin
                div_req.start = 1'b1;
                state_d       = S_DIV_HEAD;
              end
            end
            default: state_d = S_CAP_PER;
          endcase
        end
      end
      S_APP_MUL: begin
        count_d = W'(mul_p);
        state_d = S_APP_ADD;
      end
      S_APP_ADD: begin
        if (app_total[W]) begin
          status_d = zdst_pkg::ST_BAD;
        end else begin
          tbl_we    = 1'b1;
          loaded_d  = loaded_q + CntW'(1);
          surface_d = app_total[W-1:0];
        end
        state_d = S_CAP_PER;
      end
      S_DIV_HEAD: begin
        if (div_rsp.done) begin
          head_d  = div_rsp.quotient;
          rest_d  = div_rsp.remainder;
          idx_d   = '0;
          sum_d   = '0;
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        state_d = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (walk_hit) begin
          div_req.start    = 1'b1;
          div_req.dividend = rest_q - sum_q;
          div_req.divisor  = W'(spt_eff);
          state_d          = S_DIV_SEC;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          sum_d   = walk_sum[W-1:0];
          state_d = S_WALK_RD;
        end
      end
      S_DIV_SEC: begin
        if (div_rsp.done) begin
          track_d  = tbl_rdata.start_track + div_rsp.quotient[zdst_pkg::TRACK_W-1:0];
          sector_d = div_rsp.remainder[zdst_pkg::SPT_W-1:0];
          status_d = (head_q >= W'(hc_q)) ? zdst_pkg::ST_HEAD : zdst_pkg::ST_OK;
          state_d  = S_CAP_PER;
        end
      end
      S_CAP_PER: begin
        per_d   = PerW'(hc_q) * PerW'(surface_q);
        state_d = S_CAP_LO;
      end
      S_CAP_LO: begin
        acc_d   = AccW'(mul_p);
        state_d = S_CAP_HI;
      end
      S_CAP_HI: begin
        acc_d   = acc_q + {mul_p, HalfW'(0)};
        cap_d   = (acc_d[AccW-1:zdst_pkg::CAP_W] != '0) ? '1
                                                       : acc_d[zdst_pkg::CAP_W-1:0];
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      loaded_q  <= '0;
      surface_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      loaded_q  <= loaded_d;
      surface_q <= surface_d;
      valid_q   <= valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    head_q   <= head_d;
    track_q  <= track_d;
    sector_q <= sector_d;
    cap_q    <= cap_d;
    idx_q    <= idx_d;
    sum_q    <= sum_d;
    rest_q   <= rest_d;
    span_q   <= span_d;
    spt_q    <= spt_d;
    first_q  <= first_d;
    count_q  <= count_d;
    per_q    <= per_d;
    acc_q    <= acc_d;
  end

  zdst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  zdst_zone_tbl #(
    .MAX_ZONES (MAX_ZONES)
  ) u_zone_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (loaded_q[IdxW-1:0]),
    .wdata_i (tbl_wdata),
    .raddr_i (idx_q),
    .rdata_o (tbl_rdata)
  );

  assign busy             = (state_q != S_IDLE);
  assign res_valid_o      = valid_q;
  assign status_o         = status_q;
  assign head_o           = head_q;
  assign track_o          = track_q;
  assign sector_o         = sector_q;
  assign capacity_bytes_o = cap_q;

  // Checks
  `ZDST_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `ZDST_ASSERT_SAME(a_beat_idle, clk_i, rst_ni, res_valid_o, !busy)
  `ZDST_ASSERT_NEXT(a_beat_single, clk_i, rst_ni, res_valid_o, !res_valid_o)
  `ZDST_ASSERT_SAME(a_head_range, clk_i, rst_ni,
                    res_valid_o && status_o == zdst_pkg::ST_HEAD, head_o >= W'(hc_q))

endmodule

/* rtl/zdst_div.sv */
`timescale 1ns / 1ps
module zdst_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  zdst_pkg::div_req_t req_i,
  output zdst_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W    = zdst_pkg::DIV_W;
  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic [W:0]      rem_w;
  logic [W:0]      diff;

  // One quotient bit per cycle, restoring form
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_w  = {rem_q, quo_q[W-1]};
    diff   = rem_w - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_w[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/zdst_zone_tbl.sv */
`timescale 1ns / 1ps
module zdst_zone_tbl #(
  parameter int unsigned MAX_ZONES = zdst_pkg::MAX_ZONES_DEF,
  localparam int unsigned IdxW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  zdst_pkg::zone_t wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output zdst_pkg::zone_t rdata_o
);

  zdst_pkg::zone_t mem_q [MAX_ZONES];
  zdst_pkg::zone_t rdata_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
